// ===== hw/rtl/rmq_pkg.sv =====
package rmq_pkg;

  localparam int unsigned DataWidth = 16;
  localparam int unsigned FracBits  = 14;
  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned DivSteps  = 24;
  localparam int unsigned Latency   = SqrtSteps + DivSteps + 3;

  localparam logic [1:0] BrTrace = 2'd0;
  localparam logic [1:0] BrM00   = 2'd1;
  localparam logic [1:0] BrM11   = 2'd2;
  localparam logic [1:0] BrM22   = 2'd3;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } req_t;

  typedef struct packed {
    logic signed [15:0] q_w;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
    logic [1:0]         branch_used;
    logic               invalid;
  } rsp_t;

endpackage

// ===== hw/rtl/rmq_sqrt.sv =====
module rmq_sqrt (
  input  logic        clk_i,
  input  logic [31:0] rad_i,
  output logic [15:0] root_o
);

  logic [17:0] rem_q  [rmq_pkg::SqrtSteps];
  logic [15:0] root_q [rmq_pkg::SqrtSteps];
  logic [31:0] rad_q  [rmq_pkg::SqrtSteps];

  for (genvar k = 0; k < rmq_pkg::SqrtSteps; k++) begin : g_st
    logic [17:0] rem_in;
    logic [15:0] root_in;
    logic [31:0] rad_in;
    logic [19:0] rem_sh;
    logic [19:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign rem_sh = {rem_in, rad_in[31:30]};
    assign trial  = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      rad_q[k] <= {rad_in[29:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q[k]  <= 18'(rem_sh - trial);
        root_q[k] <= {root_in[14:0], 1'b1};
      end else begin
        rem_q[k]  <= rem_sh[17:0];
        root_q[k] <= {root_in[14:0], 1'b0};
      end
    end
  end

  assign root_o = root_q[rmq_pkg::SqrtSteps-1];

endmodule

// ===== hw/rtl/rmq_div.sv =====
module rmq_div (
  input  logic        clk_i,
  input  logic [31:0] num_i,
  input  logic [16:0] den_i,
  output logic [23:0] quo_o
);

  logic [16:0] rem_q [rmq_pkg::DivSteps];
  logic [23:0] num_q [rmq_pkg::DivSteps];
  logic [16:0] den_q [rmq_pkg::DivSteps];
  logic [23:0] quo_q [rmq_pkg::DivSteps];

  for (genvar k = 0; k < rmq_pkg::DivSteps; k++) begin : g_st
    logic [16:0] rem_in;
    logic [23:0] num_in;
    logic [16:0] den_in;
    logic [23:0] quo_in;
    logic [17:0] rem_sh;

    if (k == 0) begin : g_first
      assign rem_in = {9'd0, num_i[31:24]};
      assign num_in = num_i[23:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign rem_sh = {rem_in, num_in[23]};

    always_ff @(posedge clk_i) begin
      num_q[k] <= {num_in[22:0], 1'b0};
      den_q[k] <= den_in;
      if (rem_sh >= {1'b0, den_in}) begin
        rem_q[k] <= 17'(rem_sh - {1'b0, den_in});
        quo_q[k] <= {quo_in[22:0], 1'b1};
      end else begin
        rem_q[k] <= rem_sh[16:0];
        quo_q[k] <= {quo_in[22:0], 1'b0};
      end
    end
  end

  assign quo_o = quo_q[rmq_pkg::DivSteps-1];

endmodule

// ===== hw/rtl/rotation_matrix_to_quaternion_top.sv =====
// Rotation matrix (nine Q2.14 elements) to unit quaternion in Q2.14 by the
// four-branch trace method. busy_o is always low: a request is taken on every
// cycle start_i is high, and its result appears on rsp_o with done_o high for
// exactly one cycle, after the input register, 16-stage bit-pair square root,
// divider register, 24-stage restoring divider and output register (one
// request per cycle sustained). The receiver cannot stall; capture rsp_o when done_o is high.
module rotation_matrix_to_quaternion_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  rmq_pkg::req_t req_i,
  output logic          done_o,
  output rmq_pkg::rsp_t rsp_o
);

  typedef struct packed {
    logic signed [2:0][16:0] e;
    logic [1:0]              br;
    logic                    inv;
  } side1_t;

  typedef struct packed {
    logic [2:0]  neg;
    logic [15:0] big;
    logic [1:0]  br;
    logic        inv;
  } side2_t;

  function automatic logic signed [15:0] sat_f(logic [23:0] q, logic neg);
    logic signed [15:0] res;
    if (neg) begin
      res = (q > 24'd32768) ? 16'sh8000 : 16'(-q);
    end else begin
      res = (q > 24'd32767) ? 16'sh7fff : q[15:0];
    end
    return res;
  endfunction

  logic                   vld_q [rmq_pkg::Latency];
  logic signed [17:0]     tr;
  logic signed [18:0]     arg;
  logic [1:0]             br;
  logic signed [16:0]     dx, dy, dz, sxy, sxz, syz;
  side1_t                 s1_d, s1_q;
  side1_t                 s1_dly_q [rmq_pkg::SqrtSteps];
  logic [31:0]            rad_d, rad_q;
  logic [15:0]            root;
  logic [31:0]            num_q [3];
  logic [16:0]            den_q;
  side2_t                 s2_q;
  side2_t                 s2_dly_q [rmq_pkg::DivSteps];
  logic [23:0]            quo [3];
  rmq_pkg::rsp_t          rsp_d, rsp_q;

  assign busy_o = 1'b0;

  always_comb begin
    tr  = 18'(req_i.m00) + 18'(req_i.m11) + 18'(req_i.m22);
    dx  = 17'(req_i.m21) - 17'(req_i.m12);
    dy  = 17'(req_i.m02) - 17'(req_i.m20);
    dz  = 17'(req_i.m10) - 17'(req_i.m01);
    sxy = 17'(req_i.m01) + 17'(req_i.m10);
    sxz = 17'(req_i.m02) + 17'(req_i.m20);
    syz = 17'(req_i.m12) + 17'(req_i.m21);
    if (tr > 18'sd0) begin
      br  = rmq_pkg::BrTrace;
      arg = 19'(tr) + 19'sd16384;
      s1_d.e = {dx, dy, dz};
    end else if (req_i.m00 > req_i.m11 && req_i.m00 > req_i.m22) begin
      br  = rmq_pkg::BrM00;
      arg = 19'sd16384 + 19'(req_i.m00) - 19'(req_i.m11) - 19'(req_i.m22);
      s1_d.e = {dx, sxy, sxz};
    end else if (req_i.m11 > req_i.m22) begin
      br  = rmq_pkg::BrM11;
      arg = 19'sd16384 + 19'(req_i.m11) - 19'(req_i.m00) - 19'(req_i.m22);
      s1_d.e = {dy, sxy, syz};
    end else begin
      br  = rmq_pkg::BrM22;
      arg = 19'sd16384 + 19'(req_i.m22) - 19'(req_i.m00) - 19'(req_i.m11);
      s1_d.e = {dz, sxz, syz};
    end
    s1_d.br  = br;
    s1_d.inv = !(arg > 19'sd0);
    rad_d    = s1_d.inv ? 32'd0 : {1'b0, arg[16:0], 14'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rmq_pkg::Latency; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= start_i && !busy_o;
      for (int i = 1; i < rmq_pkg::Latency; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    rad_q <= rad_d;
    s1_dly_q[0] <= s1_q;
    for (int i = 1; i < rmq_pkg::SqrtSteps; i++) s1_dly_q[i] <= s1_dly_q[i-1];
  end

  rmq_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (rad_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    logic [16:0] mag;
    logic [16:0] rnd;
    for (int j = 0; j < 3; j++) begin
      mag = s1_dly_q[rmq_pkg::SqrtSteps-1].e[j][16] ?
            17'(-s1_dly_q[rmq_pkg::SqrtSteps-1].e[j]) :
            17'(s1_dly_q[rmq_pkg::SqrtSteps-1].e[j]);
      num_q[j]    <= {1'b0, mag, 14'd0} + 32'(root);
      s2_q.neg[j] <= s1_dly_q[rmq_pkg::SqrtSteps-1].e[j][16];
    end
    rnd      = 17'(root) + 17'd1;
    den_q    <= {root, 1'b0};
    s2_q.big <= (rnd[16:1] > 16'd32767) ? 16'd32767 : rnd[16:1];
    s2_q.br  <= s1_dly_q[rmq_pkg::SqrtSteps-1].br;
    s2_q.inv <= s1_dly_q[rmq_pkg::SqrtSteps-1].inv;
    s2_dly_q[0] <= s2_q;
    for (int i = 1; i < rmq_pkg::DivSteps; i++) s2_dly_q[i] <= s2_dly_q[i-1];
  end

  for (genvar j = 0; j < 3; j++) begin : g_div
    rmq_div u_div (
      .clk_i (clk_i),
      .num_i (num_q[j]),
      .den_i (den_q),
      .quo_o (quo[j])
    );
  end

  always_comb begin
    side2_t             s;
    logic signed [15:0] c [4];
    logic signed [15:0] v [3];
    s = s2_dly_q[rmq_pkg::DivSteps-1];
    for (int j = 0; j < 3; j++) v[j] = sat_f(quo[2-j], s.neg[2-j]);
    case (s.br)
      rmq_pkg::BrTrace: begin
        c[0] = s.big; c[1] = v[0]; c[2] = v[1]; c[3] = v[2];
      end
      rmq_pkg::BrM00: begin
        c[0] = v[0]; c[1] = s.big; c[2] = v[1]; c[3] = v[2];
      end
      rmq_pkg::BrM11: begin
        c[0] = v[0]; c[1] = v[1]; c[2] = s.big; c[3] = v[2];
      end
      default: begin
        c[0] = v[0]; c[1] = v[1]; c[2] = v[2]; c[3] = s.big;
      end
    endcase
    rsp_d.q_w         = s.inv ? 16'sd0 : c[0];
    rsp_d.q_x         = s.inv ? 16'sd0 : c[1];
    rsp_d.q_y         = s.inv ? 16'sd0 : c[2];
    rsp_d.q_z         = s.inv ? 16'sd0 : c[3];
    rsp_d.branch_used = s.br;
    rsp_d.invalid     = s.inv;
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = vld_q[rmq_pkg::Latency-1];
  assign rsp_o  = rsp_q;

endmodule

// ===== hw/rtl/rmq_checker.sv =====
module rmq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          done_o,
  input rmq_pkg::rsp_t rsp_o
);

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_done_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, rmq_pkg::Latency))
    else $error("result without request");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.invalid) |->
      (rsp_o.q_w == 16'sd0 && rsp_o.q_x == 16'sd0 &&
       rsp_o.q_y == 16'sd0 && rsp_o.q_z == 16'sd0))
    else $error("invalid result not zero");

  a_trace_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.branch_used == rmq_pkg::BrTrace) |->
      (!rsp_o.invalid && !rsp_o.q_w[15]))
    else $error("trace branch result malformed");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (.*);

// ===== tb/tb_rotation_matrix_to_quaternion_top.sv =====
module tb_rotation_matrix_to_quaternion_top;

  localparam int unsigned NumRandom = 1530;
  localparam longint     One       = 64'sd1 << rmq_pkg::FracBits;
  localparam longint     QMax      = (64'sd1 << (rmq_pkg::DataWidth - 1)) - 1;
  localparam longint     QMin      = -(64'sd1 << (rmq_pkg::DataWidth - 1));

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  rmq_pkg::req_t  req_i;
  logic           done_o;
  rmq_pkg::rsp_t  rsp_o;

  rmq_pkg::req_t  pending_q[$];
  rmq_pkg::rsp_t  quat_expected_q[$];
  int             mismatch_cnt;
  int             gap_left;
  bit             calm;

  rotation_matrix_to_quaternion_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic longint floor_sqrt(longint v);
    longint res;
    longint b;
    res = 0;
    b = 64'sd1 << 60;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] off_diag_part(longint d, longint r);
    longint mag;
    longint q;
    mag = (d < 0) ? -d : d;
    q = ((mag << rmq_pkg::FracBits) + r) / (2 * r);
    if (d >= 0) return (q > QMax) ? QMax[15:0] : q[15:0];
    if (q > -QMin) return QMin[15:0];
    return 16'(-q);
  endfunction

  function automatic rmq_pkg::rsp_t quat_of_matrix(rmq_pkg::req_t m);
    rmq_pkg::rsp_t o;
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
    longint tr, arg, r, big, dx, dy, dz, sxy, sxz, syz;
    logic signed [15:0] bigq;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    o = '0;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      o.branch_used = rmq_pkg::BrTrace;
      arg = tr + One;
    end else if (a00 > a11 && a00 > a22) begin
      o.branch_used = rmq_pkg::BrM00;
      arg = One + a00 - a11 - a22;
    end else if (a11 > a22) begin
      o.branch_used = rmq_pkg::BrM11;
      arg = One + a11 - a00 - a22;
    end else begin
      o.branch_used = rmq_pkg::BrM22;
      arg = One + a22 - a00 - a11;
    end
    if (arg <= 0) begin
      o.invalid = 1'b1;
      return o;
    end
    r = floor_sqrt(arg << rmq_pkg::FracBits);
    big = (r + 1) >>> 1;
    bigq = (big > QMax) ? QMax[15:0] : big[15:0];
    dx = a21 - a12; dy = a02 - a20; dz = a10 - a01;
    sxy = a01 + a10; sxz = a02 + a20; syz = a12 + a21;
    case (o.branch_used)
      rmq_pkg::BrTrace: begin
        o.q_w = bigq;
        o.q_x = off_diag_part(dx, r);
        o.q_y = off_diag_part(dy, r);
        o.q_z = off_diag_part(dz, r);
      end
      rmq_pkg::BrM00: begin
        o.q_w = off_diag_part(dx, r);
        o.q_x = bigq;
        o.q_y = off_diag_part(sxy, r);
        o.q_z = off_diag_part(sxz, r);
      end
      rmq_pkg::BrM11: begin
        o.q_w = off_diag_part(dy, r);
        o.q_x = off_diag_part(sxy, r);
        o.q_y = bigq;
        o.q_z = off_diag_part(syz, r);
      end
      default: begin
        o.q_w = off_diag_part(dz, r);
        o.q_x = off_diag_part(sxz, r);
        o.q_y = off_diag_part(syz, r);
        o.q_z = bigq;
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_cnt++;
  endtask

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'(-32768 + $urandom_range(0, 3));
      2: return 16'(32767 - $urandom_range(0, 3));
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic rmq_pkg::req_t rotation_like();
    rmq_pkg::req_t m;
    int   s;
    logic signed [15:0] v;
    m = '0;
    s = $urandom_range(0, 3);
    v = 16'($urandom_range(0, 16384));
    m.m00 = (s == 1) ? v : -16'(s) * 16'sd1000 + 16'($urandom_range(0, 2000));
    m.m11 = (s == 2) ? v : 16'($signed($urandom_range(0, 12000)) - 8000);
    m.m22 = (s == 3) ? v : 16'($signed($urandom_range(0, 12000)) - 8000);
    m.m01 = 16'($signed($urandom_range(0, 32768)) - 16384);
    m.m10 = 16'($signed($urandom_range(0, 32768)) - 16384);
    m.m02 = 16'($signed($urandom_range(0, 32768)) - 16384);
    m.m20 = 16'($signed($urandom_range(0, 32768)) - 16384);
    m.m12 = 16'($signed($urandom_range(0, 32768)) - 16384);
    m.m21 = 16'($signed($urandom_range(0, 32768)) - 16384);
    return m;
  endfunction

  function automatic rmq_pkg::req_t diag(int a, int b, int c, int off);
    rmq_pkg::req_t m;
    m = '{default: 16'(off)};
    m.m00 = 16'(a); m.m11 = 16'(b); m.m22 = 16'(c);
    return m;
  endfunction

  initial begin
    rmq_pkg::req_t m;
    mismatch_cnt = 0;
    calm         = 1'b0;
    rst_ni       = 1'b0;
    pending_q.push_back(diag(16384, 16384, 16384, 0));
    pending_q.push_back(diag(16384, -16384, -16384, 0));
    pending_q.push_back(diag(-16384, 16384, -16384, 0));
    pending_q.push_back(diag(-16384, -16384, 16384, 0));
    pending_q.push_back(diag(0, 0, 0, 0));
    pending_q.push_back(diag(-100, -100, -100, 300));
    pending_q.push_back(diag(-5000, -5000, -9000, 7));
    pending_q.push_back(diag(-5000, -9000, -9000, -7));
    pending_q.push_back(diag(-9000, -5000, -5000, 123));
    pending_q.push_back(diag(32767, -32768, -32768, 32767));
    pending_q.push_back(diag(-32768, -32768, -32768, -32768));
    pending_q.push_back(diag(-32768, 32767, -32768, 32767));
    pending_q.push_back(diag(-32768, -32768, 32767, -32768));
    pending_q.push_back(diag(-32768, -32768, -32768, 32767));
    pending_q.push_back(diag(-32000, -32000, -32000, 0));
    pending_q.push_back(diag(-32768, -32768, -32768, 0));
    pending_q.push_back(diag(32767, 32767, 32767, -32768));
    pending_q.push_back(diag(1, 0, 0, -32768));
    pending_q.push_back(diag(-16000, -16000, -16000, -1));
    m = diag(-30000, -31000, -32000, 0);
    m.m01 = 16'sd32767; m.m10 = 16'sd32767; m.m12 = -16'sd32768; m.m21 = 16'sd32767;
    pending_q.push_back(m);
    for (int i = 0; i < NumRandom; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        m = '{default: rand_elem()};
        m.m00 = rand_elem(); m.m01 = rand_elem(); m.m02 = rand_elem();
        m.m10 = rand_elem(); m.m11 = rand_elem(); m.m12 = rand_elem();
        m.m20 = rand_elem(); m.m21 = rand_elem(); m.m22 = rand_elem();
      end else begin
        m = rotation_like();
      end
      pending_q.push_back(m);
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_q.size() == 0);
    wait (quat_expected_q.size() == 0);
    repeat (rmq_pkg::Latency + 10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_rotation_matrix_to_quaternion_top OK");
    end else begin
      $display("tb_rotation_matrix_to_quaternion_top NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_rotation_matrix_to_quaternion_top NOT OK");
    $finish;
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i  <= 1'b0;
      req_i    <= '0;
      gap_left <= 0;
    end else begin
      if (start_i && !busy_o) begin
        quat_expected_q.push_back(quat_of_matrix(req_i));
        void'(pending_q.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i  <= 1'b0;
      end else if (!calm && pending_q.size() > 150 && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 15);
        start_i  <= 1'b0;
      end else if (pending_q.size() > 0) begin
        start_i <= 1'b1;
        req_i   <= pending_q[0];
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (pending_q.size() <= 150) calm <= 1'b1;
  end

  always @(posedge clk_i) begin
    rmq_pkg::rsp_t want;
    if (rst_ni && done_o) begin
      if (quat_expected_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = quat_expected_q.pop_front();
        if (rsp_o.q_w !== want.q_w) report_mismatch("q_w", rsp_o.q_w, want.q_w);
        if (rsp_o.q_x !== want.q_x) report_mismatch("q_x", rsp_o.q_x, want.q_x);
        if (rsp_o.q_y !== want.q_y) report_mismatch("q_y", rsp_o.q_y, want.q_y);
        if (rsp_o.q_z !== want.q_z) report_mismatch("q_z", rsp_o.q_z, want.q_z);
        if (rsp_o.branch_used !== want.branch_used)
          report_mismatch("branch_used", rsp_o.branch_used, want.branch_used);
        if (rsp_o.invalid !== want.invalid)
          report_mismatch("invalid", rsp_o.invalid, want.invalid);
      end
    end
  end

endmodule
